/* src/sat_pkg.sv */
package sat_pkg;

	// default table depth
	localparam int MAX_SECTIONS_DEF = 16;

	// field widths fixed by the item format
	localparam int ADDR_BITS  = 32;
	localparam int COUNT_BITS = 5;
	localparam int SLOT_BITS  = 4;
	localparam int END_BITS   = 33;

	// item kinds
	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_FO2RVA = 2'd1,
		KIND_RVA2FO = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	// control states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// one input beat
	typedef struct packed {
		kind_t                 kind;
		logic [SLOT_BITS-1:0]  entry_index;
		logic [ADDR_BITS-1:0]  query_address;
		logic [ADDR_BITS-1:0]  entry_virtual_address;
		logic [ADDR_BITS-1:0]  entry_raw_offset;
		logic [ADDR_BITS-1:0]  entry_raw_size;
		logic [ADDR_BITS-1:0]  entry_virtual_size;
	} in_t;

	// one result beat
	typedef struct packed {
		logic                 found;
		logic [END_BITS-1:0]  answer;
	} out_t;

	// one table row
	typedef struct packed {
		logic [ADDR_BITS-1:0] virtual_start;
		logic [ADDR_BITS-1:0] raw_start;
		logic [ADDR_BITS-1:0] raw_length;
		logic [ADDR_BITS-1:0] virtual_length;
	} entry_t;

endpackage

/* src/sat_table.sv */
module sat_table #(
	parameter int DEPTH  = sat_pkg::MAX_SECTIONS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  sat_pkg::entry_t      wdata,
	input  logic                 re,
	input  logic [ADDR_W-1:0]    raddr,
	output sat_pkg::entry_t      rdata
);
	import sat_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// section rows, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/section_address_translator_unit.sv */
// A load, or a query on an empty table, strobes its result in the cycle after accept.
// Any other query scans the rows in order through the table read register, the compare
// register and the result register; a translation answers on the first hit, while a miss
// or an end query answers after the last entry in use (section_count, capped). busy stays
// high for the scan, so no new beat is taken until it ends; one table row is read per cycle.
// Reset clears control state and section_count; table rows keep their contents.
// The receiver cannot stall: strobe is high for a single cycle per result.
module section_address_translator_unit #(
	parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  sat_pkg::in_t                   cmd,
	input  logic                           cfg_we,
	input  logic [sat_pkg::COUNT_BITS-1:0] cfg_wdata,
	output logic                           strobe,
	output sat_pkg::out_t                  result
);
	import sat_pkg::*;

	localparam int IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W  = $clog2(MAX_SECTIONS + 1);
	localparam int CMP_W  = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
	localparam int SLOT_W = IDX_W + SLOT_BITS;

	state_t                 state_q, state_nxt;
	logic [COUNT_BITS-1:0]  section_count_q;
	kind_t                  kind_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       iss_q;
	logic [END_BITS-1:0]    best_q;

	logic                   accept, is_query, go_scan, issue, finish;
	logic [CMP_W-1:0]       cnt_ext;
	logic [CNT_W-1:0]       n_in;
	logic [SLOT_W-1:0]      slot_ext;
	logic                   slot_ok;
	entry_t                 wr_entry, rd_entry;

	logic                   valid_s1, last_s1;
	logic                   valid_s2, last_s2;
	logic                   ge_s2;
	logic [ADDR_BITS-1:0]   dist_s2, len_s2, dest_s2;
	logic [END_BITS-1:0]    end_s2;

	logic [ADDR_BITS-1:0]   base, dest;
	logic [ADDR_BITS:0]     diff;
	logic [END_BITS-1:0]    end_sum, best_nxt;
	logic                   hit;
	logic [ADDR_BITS-1:0]   trans_ans;

	logic                   resp_vld;
	out_t                   resp;
	logic                   strobe_q;
	out_t                   result_q;

	// input beat handshake
	assign accept   = start && !busy;
	assign is_query = (cmd.kind != KIND_LOAD);

	// entries in use, capped at table depth
	assign cnt_ext = CMP_W'(section_count_q);
	assign n_in    = (cnt_ext > CMP_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS) : CNT_W'(cnt_ext);
	assign go_scan = accept && is_query && (n_in != '0);

	// load slot range check
	assign slot_ext = SLOT_W'(cmd.entry_index);
	assign slot_ok  = (slot_ext < SLOT_W'(MAX_SECTIONS));

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= '0;
		end else if (cfg_we) begin
			section_count_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (go_scan) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy  = 1'b0;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy  = 1'b0;
				issue = 1'b0;
			end
			ST_SCAN: begin
				busy  = 1'b1;
				issue = (iss_q < n_q);
			end
			default: begin
				busy  = 1'b0;
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// query context captured at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			n_q   <= '0;
		end else if (accept) begin
			iss_q <= '0;
			n_q   <= n_in;
		end else if (issue) begin
			iss_q <= iss_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			addr_q <= cmd.query_address;
		end
	end

	// section table; writes only at load accept, reads only while scanning
	assign wr_entry.virtual_start  = cmd.entry_virtual_address;
	assign wr_entry.raw_start      = cmd.entry_raw_offset;
	assign wr_entry.raw_length     = cmd.entry_raw_size;
	assign wr_entry.virtual_length = cmd.entry_virtual_size;

	sat_table #(
		.DEPTH  (MAX_SECTIONS),
		.ADDR_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (accept && (cmd.kind == KIND_LOAD) && slot_ok),
		.waddr (slot_ext[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	// read pipeline control; a finished scan drops rows still in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else if (finish) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			last_s1  <= issue && ((iss_q + CNT_W'(1)) == n_q);
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	// row compare, first half: distance into the section and end sum
	always_comb begin
		if (kind_q == KIND_FO2RVA) begin
			base = rd_entry.raw_start;
			dest = rd_entry.virtual_start;
		end else begin
			base = rd_entry.virtual_start;
			dest = rd_entry.raw_start;
		end
	end

	assign diff    = {1'b0, addr_q} - {1'b0, base};
	assign end_sum = {1'b0, rd_entry.virtual_start} + {1'b0, rd_entry.virtual_length};

	always_ff @(posedge clk) begin
		ge_s2   <= !diff[ADDR_BITS];
		dist_s2 <= diff[ADDR_BITS-1:0];
		len_s2  <= rd_entry.raw_length;
		dest_s2 <= dest;
		end_s2  <= end_sum;
	end

	// row compare, second half: bound check, translation, running maximum
	assign hit       = ge_s2 && (dist_s2 < len_s2);
	assign trans_ans = dest_s2 + dist_s2;
	assign best_nxt  = (end_s2 > best_q) ? end_s2 : best_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			best_q <= '0;
		end else if (valid_s2) begin
			best_q <= best_nxt;
		end
	end

	assign finish = (state_q == ST_SCAN) && valid_s2 &&
		(last_s2 || ((kind_q != KIND_END) && hit));

	// result selection
	always_comb begin
		resp_vld     = 1'b0;
		resp.found   = 1'b0;
		resp.answer  = '0;
		if (accept && !go_scan) begin
			resp_vld   = 1'b1;
			resp.found = (cmd.kind == KIND_LOAD) ? slot_ok : (cmd.kind == KIND_END);
		end else if (finish) begin
			resp_vld = 1'b1;
			if (kind_q == KIND_END) begin
				resp.found  = 1'b1;
				resp.answer = best_nxt;
			end else if (hit) begin
				resp.found  = 1'b1;
				resp.answer = END_BITS'(trans_ans);
			end
		end
	end

	// result register, one cycle per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= resp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_vld) begin
			result_q <= resp;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// a beat that needs no scan answers on the next cycle
	a_direct_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !go_scan) |=> strobe)
		else $error("direct beat gave no result");

	// the end of a scan answers and frees the block
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (strobe && !busy))
		else $error("scan end gave no result or stayed busy");

	// rows in the compare stage belong to a live scan
	a_s2_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (state_q == ST_SCAN))
		else $error("compare stage valid outside a scan");

	// the read pointer never passes the entries in use
	a_iss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (iss_q <= n_q))
		else $error("scan read pointer overran");

endmodule
